FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds whenever the antecedent holds, outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Checks that the consequent holds in the cycle after the antecedent holds, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

// Checks that the consequent holds in the cycle after reset is asserted.
`define ASSERT_AFTER_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("assertion failed: label");

`endif

FILE: rtl/isots_pkg.sv
// Shared constants and beat types of the ISO-TP segmenting transmitter.
`timescale 1ns / 1ps
`default_nettype none

package isots_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 12;
    localparam int unsigned ID_W    = 11;
    localparam int unsigned FRAME_W = 64;
    localparam int unsigned BUF_W   = 56;
    localparam int unsigned FILL_W  = 3;
    localparam int unsigned SEQ_W   = 4;
    localparam int unsigned NIB_W   = 4;

    localparam logic [ID_W-1:0]   TX_ID_RESET     = 11'h702;
    localparam logic [NIB_W-1:0]  PCI_SINGLE      = 4'h0;
    localparam logic [NIB_W-1:0]  PCI_FIRST       = 4'h1;
    localparam logic [NIB_W-1:0]  PCI_CONSEC      = 4'h2;
    localparam logic [LEN_W-1:0]  SF_MAX_LEN      = 12'd7;
    localparam logic [LEN_W-1:0]  FF_HEADER_BYTES = 12'd6;
    localparam logic [FILL_W-1:0] FILL_FULL       = 3'd7;
    localparam logic [SEQ_W-1:0]  SEQ_START       = 4'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  message_length;
        logic              first_byte;
    } t_byte_beat;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_data;
        logic [ID_W-1:0]    can_identifier;
        logic               last_frame;
    } t_frame_beat;

endpackage

`default_nettype wire

FILE: rtl/isots_if.sv
// Handshake interfaces for the byte input, frame output and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface isots_byte_if;
    import isots_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  message_length;
    logic              first_byte;
    modport source (output valid, output data_byte, output message_length,
                    output first_byte, input ready);
    modport sink (input valid, input data_byte, input message_length,
                  input first_byte, output ready);
endinterface

interface isots_frame_if;
    import isots_pkg::*;
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame_data;
    logic [ID_W-1:0]    can_identifier;
    logic               last_frame;
    modport source (output valid, output frame_data, output can_identifier,
                    output last_frame, input ready);
    modport sink (input valid, input frame_data, input can_identifier,
                  input last_frame, output ready);
endinterface

interface isots_cfg_if;
    import isots_pkg::*;
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] tx_identifier;
    modport source (output valid, output tx_identifier, input ready);
    modport sink (input valid, input tx_identifier, output ready);
endinterface

`default_nettype wire

FILE: rtl/isots_frame_builder.sv
// Segmentation state and frame assembly for one accepted byte per cycle in which i_step is set.
`timescale 1ns / 1ps
`default_nettype none

module isots_frame_builder (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_step,
    input  isots_pkg::t_byte_beat    i_beat,
    input  wire [isots_pkg::ID_W-1:0] i_tx_id,
    output logic                     o_emit,
    output isots_pkg::t_frame_beat   o_frame
);
    import isots_pkg::*;

    logic [LEN_W-1:0]  r_rem,  n_rem;
    logic [SEQ_W-1:0]  r_seq,  n_seq;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [BUF_W-1:0]  r_buf,  n_buf;
    logic              r_seg,  n_seg;
    logic              r_ffp,  n_ffp;

    always_comb begin
        logic [LEN_W-1:0] total;
        logic [BYTE_W-1:0] pci;
        logic              last;

        n_rem   = r_rem;
        n_seq   = r_seq;
        n_fill  = r_fill;
        n_buf   = r_buf;
        n_seg   = r_seg;
        n_ffp   = r_ffp;
        o_emit  = 1'b0;
        total   = n_rem + FF_HEADER_BYTES;
        pci     = '0;
        last    = 1'b0;

        if (i_step) begin
            if (i_beat.first_byte) begin
                n_seq  = SEQ_START;
                n_buf  = '0;
                n_fill = '0;
                n_ffp  = 1'b0;
                n_seg  = 1'b0;
                n_rem  = i_beat.message_length;
                if (i_beat.message_length > SF_MAX_LEN) begin
                    n_seg  = 1'b1;
                    n_ffp  = 1'b1;
                    n_buf  = {i_beat.message_length[BYTE_W-1:0], {(BUF_W-BYTE_W){1'b0}}};
                    n_fill = FILL_W'(1);
                end
            end

            if (n_rem != '0) begin
                for (int k = 0; k < int'(FILL_FULL); k++) begin
                    if (n_fill == FILL_W'(k)) begin
                        n_buf[BUF_W-1-BYTE_W*k -: BYTE_W] =
                            n_buf[BUF_W-1-BYTE_W*k -: BYTE_W] | i_beat.data_byte;
                    end
                end
                n_fill = n_fill + FILL_W'(1);
                n_rem  = n_rem - LEN_W'(1);
                total  = n_rem + FF_HEADER_BYTES;

                if (n_fill == FILL_FULL || n_rem == '0) begin
                    o_emit = 1'b1;
                    priority if (n_ffp) begin
                        pci   = {PCI_FIRST, total[LEN_W-1 -: NIB_W]};
                        last  = 1'b0;
                        n_ffp = 1'b0;
                    end else if (n_seg) begin
                        pci   = {PCI_CONSEC, n_seq};
                        n_seq = n_seq + SEQ_W'(1);
                        last  = (n_rem == '0);
                    end else begin
                        pci  = {PCI_SINGLE, {(NIB_W-FILL_W){1'b0}}, n_fill};
                        last = 1'b1;
                    end
                end
            end
        end

        o_frame.frame_data     = {pci, n_buf};
        o_frame.can_identifier = i_tx_id;
        o_frame.last_frame     = last;

        if (o_emit) begin
            n_buf  = '0;
            n_fill = '0;
            if (n_rem == '0) begin
                n_seg = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_seq  <= SEQ_START;
            r_fill <= '0;
            r_buf  <= '0;
            r_seg  <= 1'b0;
            r_ffp  <= 1'b0;
        end else begin
            r_rem  <= n_rem;
            r_seq  <= n_seq;
            r_fill <= n_fill;
            r_buf  <= n_buf;
            r_seg  <= n_seg;
            r_ffp  <= n_ffp;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/isots_out_stage.sv
// Result register that holds a finished frame until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module isots_out_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_load,
    input  isots_pkg::t_frame_beat i_frame,
    input  wire                    i_ready,
    output logic                   o_valid,
    output isots_pkg::t_frame_beat o_frame,
    output logic                   o_free
);
    import isots_pkg::*;

    logic        r_valid;
    t_frame_beat r_frame;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_frame = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_frame <= i_frame;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/isotp_segmenting_transmitter.sv
// Top level of the ISO-TP segmenting transmitter.
// The block takes one message byte per beat and returns 8-byte CAN frames: a single
// frame for lengths 1 to 7, else a first frame and consecutive frames with a sequence
// number that starts at 1 and wraps mod 16. It accepts one byte per cycle while ready
// is high; a frame passes the input and result registers after the beat with its last
// byte. Input ready drops only while the result register holds a frame the sink has not
// taken. A new first byte abandons any message in progress. The identifier register
// resets to 0x702; the user writes it only between messages; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module isotp_segmenting_transmitter (
    input  wire          i_clk,
    input  wire          i_rst_n,
    isots_byte_if.sink   i_byte,
    isots_frame_if.source o_frame,
    isots_cfg_if.sink    i_cfg
);
    import isots_pkg::*;

    logic            r_s1_valid;
    t_byte_beat      r_s1_beat;
    logic [ID_W-1:0] r_tx_id;
    logic            w_free;
    logic            w_step;
    logic            w_emit;
    logic            w_out_valid;
    t_frame_beat     w_built;
    t_frame_beat     w_out;

    assign i_cfg.ready  = 1'b1;
    assign i_byte.ready = !r_s1_valid || w_free;
    assign w_step       = r_s1_valid && w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_id <= TX_ID_RESET;
        end else if (i_cfg.valid) begin
            r_tx_id <= i_cfg.tx_identifier;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_s1_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_s1_beat.data_byte      <= i_byte.data_byte;
            r_s1_beat.message_length <= i_byte.message_length;
            r_s1_beat.first_byte     <= i_byte.first_byte;
        end
    end

    isots_frame_builder u_builder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_beat  (r_s1_beat),
        .i_tx_id (r_tx_id),
        .o_emit  (w_emit),
        .o_frame (w_built)
    );

    isots_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_emit),
        .i_frame (w_built),
        .i_ready (o_frame.ready),
        .o_valid (w_out_valid),
        .o_frame (w_out),
        .o_free  (w_free)
    );

    assign o_frame.valid          = w_out_valid;
    assign o_frame.frame_data     = w_out.frame_data;
    assign o_frame.can_identifier = w_out.can_identifier;
    assign o_frame.last_frame     = w_out.last_frame;

endmodule

`default_nettype wire

FILE: rtl/isots_checker.sv
// Port-level checks of the transmitter's frame output, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module isots_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [isots_pkg::FRAME_W-1:0] i_frame_data,
    input wire                          i_last_frame
);
    import isots_pkg::*;

    logic [NIB_W-1:0] w_kind;
    logic [NIB_W-1:0] w_low;

    assign w_kind = i_frame_data[FRAME_W-1 -: NIB_W];
    assign w_low  = i_frame_data[FRAME_W-NIB_W-1 -: NIB_W];

    `ASSERT_AFTER_RESET(a_idle_after_reset, i_clk, i_rst_n, !i_out_valid)
    `ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_frame_data))
    `ASSERT_IMPLY(a_pci_kind, i_clk, i_rst_n, i_out_valid, w_kind == PCI_SINGLE || w_kind == PCI_FIRST || w_kind == PCI_CONSEC)
    `ASSERT_IMPLY(a_first_not_last, i_clk, i_rst_n, i_out_valid && w_kind == PCI_FIRST, !i_last_frame)
    `ASSERT_IMPLY(a_single_shape, i_clk, i_rst_n, i_out_valid && w_kind == PCI_SINGLE, i_last_frame && w_low != '0 && w_low[NIB_W-1] == 1'b0)

endmodule

bind isotp_segmenting_transmitter isots_checker u_isots_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_frame.valid),
    .i_out_ready  (o_frame.ready),
    .i_frame_data (o_frame.frame_data),
    .i_last_frame (o_frame.last_frame)
);

`default_nettype wire
